>>> rtl/jls_pkg.sv
// shared types and constants of the jacobi linear solver
`default_nettype none
package jls_pkg;
    localparam int MAX_UNKNOWNS_DEF = 16;
    localparam int VALUE_BITS_DEF   = 32;
    localparam int ACC_BITS         = 64;
    localparam int CHG_BITS         = 40;
    localparam int SWEEP_BITS       = 16;
    localparam int SIZE_BITS        = 5;
    localparam int TOL_BITS         = 31;
    localparam int CFG_IDX_BITS     = 2;
    localparam int CFG_DATA_BITS    = 31;

    localparam logic [1:0] ACT_LOAD_COEF = 2'd0;
    localparam logic [1:0] ACT_LOAD_RHS  = 2'd1;
    localparam logic [1:0] ACT_SOLVE     = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAXIT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOL   = 2'd2;

    // datapath commands from the controller
    typedef struct packed {
        logic clr_x;     // start of solve: zero the iterate
        logic clr_acc;   // start of a row
        logic mac;       // accumulate a(i,j)*x(j)
        logic div_start; // start the divide for row i
        logic clr_chg;   // start of a sweep
        logic commit;    // copy next to current
        logic zd_chk;    // check diagonal of row
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic zdiag;
        logic below_tol;
    } t_sts;
endpackage
`default_nettype wire

>>> rtl/jacobi_linear_solver_core.sv
// a load is taken while idle; after the solve beat, the diagonal of every row is checked,
// then per sweep each of the n rows is multiply-accumulated and drained, then divided by the
// 79-step restoring divide, followed by an evaluate step, then one beat per unknown.
// one solve at a time; a solve holds off input until its last result beat.
// reset is synchronous active low; it clears control and config registers only,
// coefficient and right-hand side stores stay undefined until written.
`default_nettype none
module jacobi_linear_solver_core #(
    parameter int MAX_UNKNOWNS = jls_pkg::MAX_UNKNOWNS_DEF,
    parameter int VALUE_BITS   = jls_pkg::VALUE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [1:0]  s_axis_tuser,  // action
    input  wire logic [39:0] s_axis_tdata,  // row[3:0], col[7:4], value[39:8]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic             m_axis_tlast,
    output logic [2:0]       m_axis_tuser,  // converged, zero_diagonal, pad
    output logic [55:0]      m_axis_tdata,  // index[3:0], solution_value[35:4], sweeps_used[51:36]
    input  wire logic        i_cfg_we,
    input  wire logic [jls_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [jls_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import jls_pkg::*;
    localparam int IW = $clog2(MAX_UNKNOWNS);

    logic [4:0] r_size;
    logic [15:0] r_maxit;
    logic [30:0] r_tol;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 5'd16; r_maxit <= 16'd100; r_tol <= 31'd66;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIZE:  r_size  <= i_cfg_data[4:0];
                CFG_MAXIT: r_maxit <= i_cfg_data[15:0];
                CFG_TOL:   r_tol   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    logic w_busy, w_acc;
    assign s_axis_tready = !w_busy;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    // loads beyond the store depth are dropped
    logic w_rok, w_cok;
    assign w_rok = (32'(s_axis_tdata[3:0]) < 32'(MAX_UNKNOWNS));
    assign w_cok = (32'(s_axis_tdata[7:4]) < 32'(MAX_UNKNOWNS));

    t_cmd w_cmd;
    t_sts w_sts;
    logic [IW-1:0] w_row, w_col, w_oidx;
    logic w_cv;
    logic [31:0] w_xval;
    logic w_last, w_conv, w_zd;
    logic [15:0] w_sw;

    jls_ctrl #(.MAX_UNKNOWNS(MAX_UNKNOWNS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(w_acc && s_axis_tuser == ACT_SOLVE),
        .i_size(r_size), .i_maxit(r_maxit), .i_sts(w_sts),
        .o_cmd(w_cmd), .o_row(w_row), .o_col(w_col), .o_col_valid(w_cv),
        .o_busy(w_busy), .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_out_idx(w_oidx), .o_out_last(w_last), .o_conv(w_conv),
        .o_sweeps(w_sw), .o_zdiag(w_zd)
    );

    jls_datapath #(.MAX_UNKNOWNS(MAX_UNKNOWNS), .VALUE_BITS(VALUE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_load_coef(w_acc && s_axis_tuser == ACT_LOAD_COEF && w_rok && w_cok),
        .i_load_rhs(w_acc && s_axis_tuser == ACT_LOAD_RHS && w_rok),
        .i_lrow(IW'(s_axis_tdata[3:0])), .i_lcol(IW'(s_axis_tdata[7:4])),
        .i_lval(s_axis_tdata[39:8]),
        .i_row(w_row), .i_col(w_col), .i_col_valid(w_cv), .i_tol(r_tol),
        .i_cmd(w_cmd), .o_sts(w_sts), .i_out_idx(w_oidx), .o_xval(w_xval)
    );

    assign m_axis_tlast = w_last;
    assign m_axis_tuser = {1'b0, w_zd, w_conv};
    assign m_axis_tdata = {4'd0, w_sw, (w_zd ? 32'd0 : w_xval), 4'(w_oidx)};
endmodule
`default_nettype wire

>>> rtl/jls_ram.sv
// generic simple dual port ram (separate read and write addresses) with registered read
`default_nettype none
module jls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/jls_div.sv
// restoring divider: magnitude of num over magnitude of den, one bit per cycle
`default_nettype none
module jls_div #(
    parameter int NUM_BITS = 63,
    parameter int DEN_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [NUM_BITS-1:0] i_num,
    input  wire logic [DEN_BITS-1:0] i_den,
    output logic                     o_busy,
    output logic [NUM_BITS-1:0]      o_quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);
    logic [NUM_BITS-1:0] r_q, n_q;
    logic [DEN_BITS:0]   r_rem, n_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DEN_BITS:0]   w_trial;

    always_comb begin
        w_trial = {r_rem[DEN_BITS-1:0], r_q[NUM_BITS-1]};
        n_q     = {r_q[NUM_BITS-2:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem   = w_trial - {1'b0, r_den};
            n_q[0]  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_BITS'(NUM_BITS);
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end
    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;
endmodule
`default_nettype wire

>>> rtl/jls_datapath.sv
// datapath: matrix store, multiply-accumulate, divide, change sum
`default_nettype none
module jls_datapath #(
    parameter int MAX_UNKNOWNS = 16,
    parameter int VALUE_BITS   = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_load_coef,
    input  wire logic                              i_load_rhs,
    input  wire logic [$clog2(MAX_UNKNOWNS)-1:0]   i_lrow,
    input  wire logic [$clog2(MAX_UNKNOWNS)-1:0]   i_lcol,
    input  wire logic [31:0]                       i_lval,
    input  wire logic [$clog2(MAX_UNKNOWNS)-1:0]   i_row,
    input  wire logic [$clog2(MAX_UNKNOWNS)-1:0]   i_col,
    input  wire logic                              i_col_valid,
    input  wire logic [30:0]                       i_tol,
    input  wire jls_pkg::t_cmd                     i_cmd,
    output jls_pkg::t_sts                          o_sts,
    input  wire logic [$clog2(MAX_UNKNOWNS)-1:0]   i_out_idx,
    output logic [31:0]                            o_xval
);
    import jls_pkg::*;
    localparam int IW = $clog2(MAX_UNKNOWNS);
    localparam int DW = VALUE_BITS + 1;
    // coefficient store addressed as {row, col}
    localparam int CDEPTH = (1 << IW) * (1 << IW);
    localparam int SUMW = ((DW > CHG_BITS) ? DW : CHG_BITS) + 1;
    localparam logic signed [ACC_BITS-1:0] ACC_LIM = ACC_BITS'(64'sd1 <<< 62);
    localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // loads are sign-extended / saturated into VALUE_BITS
    logic signed [VALUE_BITS-1:0] w_lval;
    always_comb begin
        if (VALUE_BITS >= 32) w_lval = VALUE_BITS'($signed(i_lval));
        else if ($signed(i_lval) > $signed(32'(VMAX))) w_lval = VMAX;
        else if ($signed(i_lval) < $signed(32'(VMIN))) w_lval = VMIN;
        else w_lval = VALUE_BITS'($signed(i_lval));
    end

    logic [VALUE_BITS-1:0] w_a;
    jls_ram #(.WIDTH(VALUE_BITS), .DEPTH(CDEPTH)) u_coef (
        .i_clk  (i_clk),
        .i_we   (i_load_coef),
        .i_waddr({i_lrow, i_lcol}),
        .i_wdata(w_lval),
        .i_raddr({i_row, i_col}),
        .o_rdata(w_a)
    );

    logic signed [VALUE_BITS-1:0] r_rhs [MAX_UNKNOWNS];
    logic signed [VALUE_BITS-1:0] r_x   [MAX_UNKNOWNS];
    logic signed [VALUE_BITS-1:0] r_nx  [MAX_UNKNOWNS];

    always_ff @(posedge i_clk) begin
        if (i_load_rhs) r_rhs[i_lrow] <= w_lval;
    end

    // stage 1: operands registered (a arrives in the cycle after its address)
    logic r_mac_d, r_zd_d, r_dcol_d;
    logic [IW-1:0] r_col_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_d <= 1'b0;
            r_zd_d  <= 1'b0;
        end else begin
            r_mac_d <= i_cmd.mac && i_col_valid;
            r_zd_d  <= i_cmd.zd_chk;
        end
        r_col_d  <= i_col;
        r_dcol_d <= (i_col == i_row);
    end

    // magnitude product, registered
    logic [VALUE_BITS-1:0] w_ma, w_mx;
    logic signed [VALUE_BITS-1:0] w_xj;
    logic [2*VALUE_BITS-1:0] r_prod;
    logic r_pneg, r_pv;
    assign w_xj = r_x[r_col_d];
    assign w_ma = w_a[VALUE_BITS-1] ? VALUE_BITS'(-$signed(w_a)) : w_a;
    assign w_mx = w_xj[VALUE_BITS-1] ? VALUE_BITS'(-w_xj) : w_xj;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pv <= 1'b0;
        else r_pv <= r_mac_d && !r_dcol_d;
        r_prod <= w_ma * w_mx;
        r_pneg <= w_a[VALUE_BITS-1] ^ w_xj[VALUE_BITS-1];
    end

    // truncate to q16.16, clamp magnitude at 2^62
    logic [2*VALUE_BITS-17:0] w_pm;
    logic signed [ACC_BITS-1:0] w_term, w_sum, w_sat;
    logic signed [ACC_BITS-1:0] r_acc_q;
    assign w_pm = r_prod[2*VALUE_BITS-1:16];
    always_comb begin
        if (ACC_BITS'(w_pm) > ACC_BITS'(ACC_LIM)) w_term = ACC_LIM;
        else w_term = $signed(ACC_BITS'(w_pm));
        if (r_pneg) w_term = -w_term;
        w_sum = r_acc_q + w_term;
        if (w_sum > ACC_LIM) w_sat = ACC_LIM;
        else if (w_sum < -ACC_LIM) w_sat = -ACC_LIM;
        else w_sat = w_sum;
    end

    logic signed [VALUE_BITS-1:0] r_diag;
    logic r_zdiag;
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_acc) r_acc_q <= '0;
        else if (r_pv) r_acc_q <= w_sat;
        if (r_mac_d && r_dcol_d) r_diag <= w_a;
        if (!i_rst_n) r_zdiag <= 1'b0;
        else if (i_cmd.clr_x) r_zdiag <= 1'b0;
        else if (r_zd_d && w_a == '0) r_zdiag <= 1'b1;
    end

    // numerator b - acc, sign/magnitude into divider (num << 16 fits 79 bits)
    logic signed [ACC_BITS-1:0] w_num, w_nsat;
    logic [ACC_BITS-2:0] w_nmag;
    logic [VALUE_BITS-1:0] w_dmag;
    localparam int NB = ACC_BITS - 1 + 16;
    always_comb begin
        w_num = ACC_BITS'(r_rhs[i_row]) - r_acc_q;
        if (w_num > ACC_LIM) w_nsat = ACC_LIM;
        else if (w_num < -ACC_LIM) w_nsat = -ACC_LIM;
        else w_nsat = w_num;
        w_nmag = w_nsat[ACC_BITS-1] ? (ACC_BITS-1)'(-w_nsat) : (ACC_BITS-1)'(w_nsat);
        w_dmag = r_diag[VALUE_BITS-1] ? VALUE_BITS'(-r_diag) : r_diag;
    end

    logic r_qneg;
    logic [IW-1:0] r_qrow;
    logic r_dpend;
    logic [NB-1:0] w_quot;
    logic w_dbusy;
    jls_div #(.NUM_BITS(NB), .DEN_BITS(VALUE_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  ({w_nmag, 16'd0}),
        .i_den  (w_dmag),
        .o_busy (w_dbusy),
        .o_quot (w_quot)
    );

    // divider result -> saturated next iterate, change accumulation
    logic signed [VALUE_BITS-1:0] w_nv;
    logic [VALUE_BITS:0] w_d;
    logic [SUMW-1:0] w_chg;
    logic [CHG_BITS-1:0] r_chg;
    always_comb begin
        if (w_quot > NB'(VMAX) + NB'(r_qneg)) w_nv = r_qneg ? VMIN : VMAX;
        else w_nv = r_qneg ? VALUE_BITS'(-$signed({1'b0, w_quot[VALUE_BITS-1:0]}))
                           : VALUE_BITS'(w_quot);
        w_d = ($signed({w_nv[VALUE_BITS-1], w_nv}) >= $signed({r_x[r_qrow][VALUE_BITS-1], r_x[r_qrow]}))
            ? DW'({w_nv[VALUE_BITS-1], w_nv} - {r_x[r_qrow][VALUE_BITS-1], r_x[r_qrow]})
            : DW'({r_x[r_qrow][VALUE_BITS-1], r_x[r_qrow]} - {w_nv[VALUE_BITS-1], w_nv});
        w_chg = SUMW'(r_chg) + SUMW'(w_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dpend <= 1'b0;
        else if (i_cmd.div_start) r_dpend <= 1'b1;
        else if (r_dpend && !w_dbusy) r_dpend <= 1'b0;
        if (i_cmd.div_start) begin
            r_qneg <= w_nsat[ACC_BITS-1] ^ r_diag[VALUE_BITS-1];
            r_qrow <= i_row;
        end
        if (i_cmd.clr_chg) r_chg <= '0;
        else if (r_dpend && !w_dbusy && !i_cmd.div_start) begin
            r_chg <= (w_chg > SUMW'({CHG_BITS{1'b1}})) ? {CHG_BITS{1'b1}}
                                                       : w_chg[CHG_BITS-1:0];
            r_nx[r_qrow] <= w_nv;
        end
        for (int k = 0; k < MAX_UNKNOWNS; k++) begin
            if (i_cmd.clr_x) r_x[k] <= '0;
            else if (i_cmd.commit) r_x[k] <= r_nx[k];
        end
    end

    assign o_sts.div_busy  = w_dbusy || r_dpend || i_cmd.div_start;
    assign o_sts.zdiag     = r_zdiag;
    assign o_sts.below_tol = (r_chg < CHG_BITS'(i_tol));

    // saturate iterate to 32 bits for output
    always_comb begin
        if (VALUE_BITS <= 32) o_xval = 32'($signed(r_x[i_out_idx]));
        else if (r_x[i_out_idx] > $signed(VALUE_BITS'(32'h7fffffff))) o_xval = 32'h7fffffff;
        else if (r_x[i_out_idx] < -$signed(VALUE_BITS'(33'h080000000))) o_xval = 32'h80000000;
        else o_xval = 32'(r_x[i_out_idx]);
    end
endmodule
`default_nettype wire

>>> rtl/jls_ctrl.sv
// controller: sequences zero check, sweeps, rows and result beats
`default_nettype none
module jls_ctrl #(
    parameter int MAX_UNKNOWNS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [4:0]                      i_size,
    input  wire logic [15:0]                     i_maxit,
    input  wire jls_pkg::t_sts                   i_sts,
    output jls_pkg::t_cmd                        o_cmd,
    output logic [$clog2(MAX_UNKNOWNS)-1:0]      o_row,
    output logic [$clog2(MAX_UNKNOWNS)-1:0]      o_col,
    output logic                                 o_col_valid,
    output logic                                 o_busy,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [$clog2(MAX_UNKNOWNS)-1:0]      o_out_idx,
    output logic                                 o_out_last,
    output logic                                 o_conv,
    output logic [15:0]                          o_sweeps,
    output logic                                 o_zdiag
);
    import jls_pkg::*;
    localparam int IW = $clog2(MAX_UNKNOWNS);
    localparam int CW = IW + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ZCHK  = 7'b0000010,
        S_ZWAIT = 7'b0000100,
        S_ROW   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_EVAL  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_st, n_st;
    logic [CW-1:0] r_n, r_i, r_j;
    logic [15:0] r_sw;
    logic r_conv;
    logic [2:0] r_wait;
    logic [CW-1:0] w_n;

    always_comb begin
        if (i_size == '0) w_n = CW'(1);
        else if (32'(i_size) > 32'(MAX_UNKNOWNS)) w_n = CW'(MAX_UNKNOWNS);
        else w_n = CW'(i_size);
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.clr_x   = (r_st == S_IDLE) && i_start;
        o_cmd.zd_chk  = (r_st == S_ZCHK);
        o_cmd.mac     = (r_st == S_ROW) && (r_j < r_n);
        o_cmd.clr_acc = ((r_st == S_DIV) && (r_wait == '0) && !i_sts.div_busy)
                        || o_cmd.clr_x;
        o_cmd.div_start = (r_st == S_ROW) && (r_j == r_n) && (r_wait == 3'd4);
        o_cmd.clr_chg = o_cmd.clr_x || ((r_st == S_EVAL) && !i_sts.below_tol
                        && (r_sw != i_maxit));
        o_cmd.commit  = (r_st == S_EVAL) && !i_sts.below_tol;
    end
    assign o_row = IW'(r_i);
    assign o_col = (r_st == S_ZCHK) ? IW'(r_i) : IW'(r_j);
    assign o_col_valid = o_cmd.mac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_i <= '0; r_j <= '0; r_n <= '0; r_sw <= '0;
            r_conv <= 1'b0; r_wait <= '0;
        end else begin
            case (r_st)
                S_IDLE: if (i_start) begin
                    r_n <= w_n; r_i <= '0; r_sw <= '0; r_conv <= 1'b0;
                    r_st <= S_ZCHK;
                end
                S_ZCHK: begin
                    if (r_i == r_n - 1'b1) begin
                        r_st <= S_ZWAIT; r_wait <= '0;
                    end else r_i <= r_i + 1'b1;
                end
                S_ZWAIT: begin
                    r_wait <= r_wait + 1'b1;
                    if (r_wait == 3'd2) begin
                        r_i <= '0; r_j <= '0;
                        if (i_sts.zdiag || i_maxit == '0) r_st <= S_OUT;
                        else begin r_st <= S_ROW; r_sw <= 16'd1; r_wait <= '0; end
                    end
                end
                S_ROW: begin
                    // walk columns, then drain the mac pipe before divide
                    if (r_j < r_n) r_j <= r_j + 1'b1;
                    else if (r_wait == 3'd4) begin r_st <= S_DIV; r_wait <= 3'd1; end
                    else r_wait <= r_wait + 1'b1;
                end
                S_DIV: begin
                    if (r_wait != '0) r_wait <= '0;
                    else if (!i_sts.div_busy) begin
                        r_j <= '0;
                        if (r_i == r_n - 1'b1) begin r_st <= S_EVAL; r_i <= '0; end
                        else begin r_i <= r_i + 1'b1; r_st <= S_ROW; end
                    end
                end
                S_EVAL: begin
                    if (i_sts.below_tol) begin r_conv <= 1'b1; r_st <= S_OUT; end
                    else if (r_sw == i_maxit) r_st <= S_OUT;
                    else begin r_sw <= r_sw + 1'b1; r_st <= S_ROW; end
                end
                S_OUT: if (i_out_ready) begin
                    if (r_i == r_n - 1'b1) r_st <= S_IDLE;
                    else r_i <= r_i + 1'b1;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_st != S_IDLE);
    assign o_out_valid = (r_st == S_OUT);
    assign o_out_idx   = IW'(r_i);
    assign o_out_last  = (r_i == r_n - 1'b1);
    assign o_conv      = r_conv;
    assign o_sweeps    = i_sts.zdiag ? 16'd0 : r_sw;
    assign o_zdiag     = i_sts.zdiag;

`ifndef SYNTHESIS
    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE) |-> !o_out_valid) else $error("result beat while idle");
    a_sweep_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_ROW) |-> (r_sw <= i_maxit)) else $error("sweep count past limit");
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT) |-> (r_i < r_n)) else $error("result index out of range");
    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_st == S_IDLE) && i_start) |=> (r_st == S_ZCHK)) else $error("solve not started");
`endif
endmodule
`default_nettype wire
